// ----- rtl/core/ffap_pkg.sv -----
// ----------------------------------------------------------------------------
// ffap_pkg
// Shared types and constants for the fixed frame angle parser.
// ----------------------------------------------------------------------------
package ffap_pkg;

	// frame layout
	localparam int unsigned PAYLOAD_LEN = 16;
	localparam int unsigned CNT_W       = 5;

	localparam logic [7:0] HDR0_BYTE = 8'hAA;
	localparam logic [7:0] HDR1_BYTE = 8'hAF;
	localparam logic [7:0] HDR2_BYTE = 8'h03;
	localparam logic [7:0] LEN_BYTE  = 8'(PAYLOAD_LEN);

	// payload positions of the kept angle bytes (big-endian)
	localparam logic [CNT_W-1:0] YAW_HI_IDX   = CNT_W'(2);
	localparam logic [CNT_W-1:0] YAW_LO_IDX   = CNT_W'(3);
	localparam logic [CNT_W-1:0] PITCH_HI_IDX = CNT_W'(6);
	localparam logic [CNT_W-1:0] PITCH_LO_IDX = CNT_W'(7);
	localparam logic [CNT_W-1:0] LAST_IDX     = CNT_W'(PAYLOAD_LEN - 1);

	// tdata widths
	localparam int unsigned IN_W  = 8;
	localparam int unsigned OUT_W = 32;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_HDR2    = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CSUM    = 3'd5
	} phase_t;

endpackage

// ----- rtl/core/fixed_frame_angle_parser_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_frame_angle_parser_unit
// Byte-serial frame parser that pulls yaw and pitch out of a checksummed frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per transaction. A frame is AA AF 03,
//   a length byte of PAYLOAD_LEN, PAYLOAD_LEN payload bytes and a byte that
//   is the 8-bit wrapping sum of header and payload.
//   m_axis carries one transaction per frame whose checksum matches:
//   yaw from payload bytes 2..3 and pitch from bytes 6..7, signed, big-endian,
//   in hundredths of a degree. Bad frames produce nothing.
//   Throughput: one byte per cycle while the receiver does not stall. The
//   accepted byte sits in an input register; when it is processed, the parser
//   state and the result register update together, so a result reaches m_axis
//   from the result register after its checksum byte leaves the input register.
//   Reset clears the parser to hunt for the first header byte and empties
//   both registers. When the receiver stalls with a result pending, at most
//   one more byte is taken into the input register, then s_axis_tready drops
//   until the result leaves.
// ----------------------------------------------------------------------------
module fixed_frame_angle_parser_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [ffap_pkg::IN_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [ffap_pkg::OUT_W-1:0] m_axis_tdata   // [15:0] yaw_hundredths,
	                                                  // [31:16] pitch_hundredths
);
	import ffap_pkg::*;

	// input stage
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance_s1;

	// parser state
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [7:0]       sum_q, sum_d;
	logic [15:0]      yaw_q, yaw_d;
	logic [15:0]      pitch_q, pitch_d;
	logic             result_hit;

	// result register
	logic             out_valid_q;
	logic [15:0]      out_yaw_q;
	logic [15:0]      out_pitch_q;

	assign advance_s1    = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata[7:0];
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HDR1:    phase_d = (byte_s1 == HDR1_BYTE) ? PH_HDR2 : PH_HDR0;
			PH_HDR2:    phase_d = (byte_s1 == HDR2_BYTE) ? PH_LEN  : PH_HDR0;
			PH_LEN:     phase_d = (byte_s1 == LEN_BYTE)  ? PH_PAYLOAD : PH_HDR0;
			PH_PAYLOAD: phase_d = (count_q == LAST_IDX)  ? PH_CSUM : PH_PAYLOAD;
			PH_CSUM:    phase_d = PH_HDR0;
			default:    phase_d = (byte_s1 == HDR0_BYTE) ? PH_HDR1 : PH_HDR0;
		endcase
	end

	// datapath updates per phase
	always_comb begin
		count_d    = count_q;
		sum_d      = sum_q;
		yaw_d      = yaw_q;
		pitch_d    = pitch_q;
		result_hit = 1'b0;
		case (phase_q)
			PH_HDR1: begin
				if (byte_s1 == HDR1_BYTE) sum_d = sum_q + byte_s1;
			end
			PH_HDR2: begin
				if (byte_s1 == HDR2_BYTE) sum_d = sum_q + byte_s1;
			end
			PH_LEN: begin
				if (byte_s1 == LEN_BYTE) sum_d = sum_q + byte_s1;
				count_d = '0;
			end
			PH_PAYLOAD: begin
				sum_d = sum_q + byte_s1;
				if (count_q == YAW_HI_IDX)   yaw_d[15:8]   = byte_s1;
				if (count_q == YAW_LO_IDX)   yaw_d[7:0]    = byte_s1;
				if (count_q == PITCH_HI_IDX) pitch_d[15:8] = byte_s1;
				if (count_q == PITCH_LO_IDX) pitch_d[7:0]  = byte_s1;
				count_d = (count_q == LAST_IDX) ? '0 : count_q + 1'b1;
			end
			PH_CSUM: begin
				result_hit = (sum_q == byte_s1);
			end
			default: begin
				// start of hunt: sum restarts from the first header byte
				sum_d = (byte_s1 == HDR0_BYTE) ? byte_s1 : 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (valid_s1 && advance_s1) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s1) begin
			yaw_q   <= yaw_d;
			pitch_q <= pitch_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= valid_s1 && result_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1 && result_hit) begin
			out_yaw_q   <= yaw_q;
			out_pitch_q <= pitch_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_pitch_q, out_yaw_q};

`ifndef SYNTH
	// a new result only comes from a processed checksum byte
	a_result_from_csum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s1 && phase_q == PH_CSUM))
		else $error("result without checksum byte");

	// input backpressure only while both stages are occupied
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a full pipeline");

	// payload counter is idle outside the payload phase
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_PAYLOAD |-> count_q == '0)
		else $error("payload counter busy outside payload phase");

	// payload counter stays inside the frame
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> count_q <= LAST_IDX)
		else $error("payload counter overran frame");
`endif

endmodule
